// ----- hdl/std_atmosphere_interpolator_defines.svh -----
// Assertion macros shared by the interpolator modules.
`ifndef STD_ATMOSPHERE_INTERPOLATOR_DEFINES_SVH
`define STD_ATMOSPHERE_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTH
`define SAI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sai assertion failed");
`define SAI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sai assertion failed");
`else
`define SAI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SAI_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/sai_pkg.sv -----
package sai_pkg;

  localparam int NUM_POINTS = 23;
  localparam int FRAC_BITS  = 3;
  localparam int UNIT       = 1 << FRAC_BITS;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 5;
  localparam int IN_W       = 21;
  localparam int KEY_W      = 22;
  localparam int DIFF_W     = 23;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int NUM_W      = 46;
  localparam int STEP_W     = 6;
  localparam int RES_W      = 48;

  localparam logic signed [RES_W-1:0] OUT_LOW  = -48'sd65536;
  localparam logic signed [RES_W-1:0] OUT_HIGH = 48'sd1048575;

  // Standard atmosphere breakpoints, rising pressure and falling height.
  localparam int PRESSURE_TAB [NUM_POINTS] = '{
    1000, 2000, 3000, 4000, 5000, 7000, 10000, 15000, 20000, 22600, 25000,
    30000, 40000, 50000, 60000, 70000, 80000, 85000, 90000, 95000, 100000,
    101325, 105000};
  localparam int HEIGHT_TAB [NUM_POINTS] = '{
    31055, 26481, 23849, 22000, 20576, 18442, 16180, 13608, 11784, 11000,
    10363, 9164, 7185, 5574, 4206, 3012, 1949, 1457, 988, 540, 111, 0, -302};

  typedef enum logic [1:0] {FR_IDLE, FR_SCAN, FR_PUSH} front_state_t;
  typedef enum logic [2:0] {BK_IDLE, BK_MUL, BK_PREP, BK_DIV, BK_FIN, BK_OUT} back_state_t;

  // One classified request passed from the front to the back.
  typedef struct packed {
    logic                   kind;
    logic signed [IN_W-1:0] x;
    logic [IDX_W-1:0]       seg;
  } seg_req_t;

  // Key j in ascending order for the given direction, in fixed point.
  function automatic logic signed [KEY_W-1:0] key_at(logic kind, logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    int v;
    r = IDX_W'(NUM_POINTS - 1) - idx;
    v = 0;
    if (!kind) begin
      if (idx < IDX_W'(NUM_POINTS)) v = PRESSURE_TAB[idx];
    end else begin
      if (r < IDX_W'(NUM_POINTS)) v = HEIGHT_TAB[r];
    end
    return KEY_W'(v * UNIT);
  endfunction

  // The value paired with key j, in fixed point.
  function automatic logic signed [KEY_W-1:0] val_at(logic kind, logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    int v;
    r = IDX_W'(NUM_POINTS - 1) - idx;
    v = 0;
    if (!kind) begin
      if (idx < IDX_W'(NUM_POINTS)) v = HEIGHT_TAB[idx];
    end else begin
      if (r < IDX_W'(NUM_POINTS)) v = PRESSURE_TAB[r];
    end
    return KEY_W'(v * UNIT);
  endfunction

endpackage

// ----- hdl/sai_front.sv -----
module sai_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic signed [sai_pkg::IN_W-1:0] in_value,
  output logic                           push,
  output sai_pkg::seg_req_t              push_req,
  input  logic                           q_full
);
  import sai_pkg::*;

  front_state_t state, state_next;
  logic                   cur_kind;
  logic signed [IN_W-1:0] cur_x;
  logic [IDX_W-1:0]       j;
  logic [CNT_W-1:0]       cnt;
  logic                   key_le;
  logic [IDX_W-1:0]       seg;

  // One key compared per cycle during the scan.
  assign key_le = key_at(cur_kind, j) <= KEY_W'(cur_x);

  // Segment start: keys not above the value, less one, clamped.
  always_comb begin
    if (cnt == '0) begin
      seg = '0;
    end else if (cnt > CNT_W'(NUM_POINTS - 1)) begin
      seg = IDX_W'(NUM_POINTS - 2);
    end else begin
      seg = IDX_W'(cnt - 1'b1);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (in_valid) state_next = FR_SCAN;
      FR_SCAN: if (j == IDX_W'(NUM_POINTS - 1)) state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall = (state != FR_IDLE);
    push     = (state == FR_PUSH) && !q_full;
    push_req = '{kind: cur_kind, x: cur_x, seg: seg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and key scan.
  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      cur_kind <= kind;
      cur_x    <= in_value;
      j        <= '0;
      cnt      <= '0;
    end else if (state == FR_SCAN) begin
      cnt <= cnt + CNT_W'(key_le);
      if (j != IDX_W'(NUM_POINTS - 1)) j <= j + 1'b1;
    end
  end

endmodule

// ----- hdl/sai_queue.sv -----
`include "std_atmosphere_interpolator_defines.svh"
module sai_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sai_pkg::seg_req_t push_req,
  output logic              full,
  input  logic              pop,
  output sai_pkg::seg_req_t pop_req,
  output logic              empty
);
  import sai_pkg::*;

  seg_req_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_req = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_req;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `SAI_ASSERT_IMP(a_no_overflow, clk, rst, push, !full)
  `SAI_ASSERT_IMP(a_no_underflow, clk, rst, pop, !empty)
  `SAI_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count != 2'd3)

endmodule

// ----- hdl/sai_back.sv -----
`include "std_atmosphere_interpolator_defines.svh"
module sai_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  sai_pkg::seg_req_t                q_req,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [sai_pkg::IN_W-1:0]  out_value,
  output logic                             saturated
);
  import sai_pkg::*;

  back_state_t state, state_next;
  seg_req_t                 req;
  logic signed [KEY_W-1:0]  k0, k1, v0c, v1c;
  logic signed [KEY_W-1:0]  v0;
  logic signed [KEY_W-1:0]  dk;
  logic signed [PROD_W-1:0] prod;
  logic                     neg;
  logic                     zero_seg;
  logic [NUM_W-1:0]         num;
  logic [KEY_W-1:0]         rem;
  logic [KEY_W:0]           trial;
  logic [STEP_W-1:0]        step;
  logic signed [RES_W-1:0]  res;
  logic [NUM_W-1:0]         mag;

  // Segment end points from the constant table.
  always_comb begin
    k0  = key_at(req.kind, req.seg);
    k1  = key_at(req.kind, req.seg + 1'b1);
    v0c = val_at(req.kind, req.seg);
    v1c = val_at(req.kind, req.seg + 1'b1);
  end

  // Restoring division: one quotient bit a cycle.
  assign trial = {rem, num[NUM_W-1]};

  // Signed result from start value and rounded quotient.
  always_comb begin
    if (zero_seg) begin
      res = RES_W'(v0);
    end else if (neg) begin
      res = RES_W'(v0) - $signed({2'b00, num});
    end else begin
      res = RES_W'(v0) + $signed({2'b00, num});
    end
  end

  // Magnitude of the product.
  assign mag = prod[PROD_W-1] ? NUM_W'(-prod) : NUM_W'(prod);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_MUL;
      BK_MUL:  state_next = BK_PREP;
      BK_PREP: state_next = BK_DIV;
      BK_DIV:  if (step == STEP_W'(NUM_W - 1)) state_next = BK_FIN;
      BK_FIN:  state_next = BK_OUT;
      BK_OUT:  if (!out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    pop       = (state == BK_IDLE) && !q_empty;
    out_valid = (state == BK_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) req <= q_req;
      end
      BK_MUL: begin
        dk   <= k1 - k0;
        v0   <= v0c;
        prod <= (DIFF_W'(v1c) - DIFF_W'(v0c)) * (DIFF_W'(req.x) - DIFF_W'(k0));
      end
      BK_PREP: begin
        neg      <= prod[PROD_W-1];
        zero_seg <= (dk <= 0);
        num      <= mag + NUM_W'(dk[KEY_W-1:1]);
        rem      <= '0;
        step     <= '0;
      end
      BK_DIV: begin
        if (trial >= {1'b0, dk}) begin
          rem <= KEY_W'(trial - {1'b0, dk});
          num <= {num[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[KEY_W-1:0];
          num <= {num[NUM_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
      end
      BK_FIN: begin
        if (res > OUT_HIGH) begin
          out_value <= IN_W'(OUT_HIGH);
          saturated <= 1'b1;
        end else if (res < OUT_LOW) begin
          out_value <= IN_W'(OUT_LOW);
          saturated <= 1'b1;
        end else begin
          out_value <= IN_W'(res);
          saturated <= 1'b0;
        end
      end
      BK_OUT: ;
      default: ;
    endcase
  end

  `SAI_ASSERT_IMP(a_pop_idle, clk, rst, pop, state == BK_IDLE)
  `SAI_ASSERT_IMP(a_step_bound, clk, rst, state == BK_DIV, step < STEP_W'(NUM_W))
  `SAI_ASSERT_NXT(a_fin_to_out, clk, rst, state == BK_FIN, out_valid)

endmodule

// ----- hdl/std_atmosphere_interpolator.sv -----
// Standard-atmosphere pressure/height converter. kind 0 turns a pressure
// (1/8 Pa) into a height (1/8 m), kind 1 the reverse, by linear
// interpolation over a fixed 23-point table, extrapolating from the end
// segments and clamping the result to -65536..1048575 with the saturated
// flag set. A front stage scans the table one key a cycle and a back
// stage multiplies, then runs a 46-step restoring divider. The two stages
// are parted by a two-entry queue, so the front can scan a new request
// while the back is still dividing the last one.
module std_atmosphere_interpolator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic signed [sai_pkg::IN_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [sai_pkg::IN_W-1:0] out_value,
  output logic                            saturated
);
  import sai_pkg::*;

  logic     push, pop, q_full, q_empty;
  seg_req_t push_req, pop_req;

  sai_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .in_value(in_value), .push(push), .push_req(push_req),
    .q_full(q_full)
  );

  sai_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_req(push_req), .full(q_full),
    .pop(pop), .pop_req(pop_req), .empty(q_empty)
  );

  sai_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_req(pop_req), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .saturated(saturated)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sai_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   kind;
  logic signed [IN_W-1:0] in_value;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [IN_W-1:0] out_value;
  logic                   saturated;

  // One request waiting to be sent; hold makes the sender wait for an empty pipe first.
  typedef struct {
    logic                   kind;
    logic signed [IN_W-1:0] value;
    logic                   hold;
  } conv_req_t;

  typedef struct {
    logic signed [IN_W-1:0] value;
    logic                   sat;
  } conv_res_t;

  conv_req_t pending_reqs[$];
  conv_res_t expected_res[$];
  int        errors = 0;
  int        in_gap;
  int        out_gap;
  logic      in_fire;

  std_atmosphere_interpolator DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .in_value(in_value), .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .saturated(saturated)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Table key j in ascending key order, scaled to 1/8 units.
  function automatic longint tab_key(logic dir, int j);
    if (!dir) return longint'(PRESSURE_TAB[j]) * UNIT;
    return longint'(HEIGHT_TAB[NUM_POINTS - 1 - j]) * UNIT;
  endfunction

  function automatic longint tab_partner(logic dir, int j);
    if (!dir) return longint'(HEIGHT_TAB[j]) * UNIT;
    return longint'(PRESSURE_TAB[NUM_POINTS - 1 - j]) * UNIT;
  endfunction

  // Interpolates over the bracketing segment, rounding half away from zero, then clamps.
  function automatic conv_res_t convert(logic dir, logic signed [IN_W-1:0] v);
    conv_res_t r;
    longint x, k0, dk, num, span, res;
    int cnt, seg;
    x = v;
    cnt = 0;
    for (int j = 0; j < NUM_POINTS; j++)
      if (tab_key(dir, j) <= x) cnt++;
    seg = cnt - 1;
    if (seg > NUM_POINTS - 2) seg = NUM_POINTS - 2;
    if (seg < 0) seg = 0;
    k0 = tab_key(dir, seg);
    dk = tab_key(dir, seg + 1) - k0;
    span = tab_partner(dir, seg + 1) - tab_partner(dir, seg);
    res = tab_partner(dir, seg);
    if (dk > 0) begin
      num = span * (x - k0);
      if (num >= 0) res += (num + dk / 2) / dk;
      else res -= (-num + dk / 2) / dk;
    end
    r.sat = 1'b0;
    if (res > 1048575) begin
      res = 1048575;
      r.sat = 1'b1;
    end else if (res < -65536) begin
      res = -65536;
      r.sat = 1'b1;
    end
    r.value = res[IN_W-1:0];
    return r;
  endfunction

  function automatic void add_req(logic k, logic signed [IN_W-1:0] v, logic h);
    conv_req_t q;
    q.kind = k;
    q.value = v;
    q.hold = h;
    pending_reqs.push_back(q);
  endfunction

  // Sender: presents requests at the falling edge, with random gaps until the final stretch.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      kind <= 1'b0;
      in_value <= '0;
      in_gap <= 0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].hold && expected_res.size() != 0)) begin
        in_valid <= 1'b1;
        kind <= pending_reqs[0].kind;
        in_value <= pending_reqs[0].value;
        void'(pending_reqs.pop_front());
        if (pending_reqs.size() > 200 && $urandom_range(0, 3) == 0)
          in_gap <= $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls in random bursts while plenty of requests remain.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (pending_reqs.size() > 200 && $urandom_range(0, 3) == 0) begin
      out_gap <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: records accepted requests and checks each accepted result in order.
  always @(posedge clk) begin
    conv_res_t exp_r;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) expected_res.push_back(convert(kind, in_value));
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %0d sat %0d", out_value, saturated);
        end else begin
          exp_r = expected_res.pop_front();
          if (exp_r.value !== out_value || exp_r.sat !== saturated) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %0d sat %0d, got %0d sat %0d",
                       exp_r.value, exp_r.sat, out_value, saturated);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int sel, j;
    logic k;
    rst = 1'b1;
    // Field extremes, exact keys, ends of the table and out-of-range patterns.
    add_req(1'b0, -21'sd65536, 1'b0);
    add_req(1'b0, 21'sd1048575, 1'b0);
    add_req(1'b1, -21'sd65536, 1'b0);
    add_req(1'b1, 21'sd1048575, 1'b0);
    add_req(1'b0, 21'h100000, 1'b0);
    add_req(1'b1, 21'h100000, 1'b0);
    add_req(1'b0, 21'sd0, 1'b0);
    add_req(1'b1, 21'sd0, 1'b0);
    add_req(1'b1, -21'sd1, 1'b0);
    add_req(1'b0, 21'sd8000, 1'b0);
    add_req(1'b0, 21'sd840000, 1'b0);
    add_req(1'b0, 21'sd810600, 1'b0);
    add_req(1'b0, 21'sd180800, 1'b0);
    add_req(1'b0, 21'sd180801, 1'b0);
    add_req(1'b1, 21'sd248440, 1'b0);
    add_req(1'b1, -21'sd2416, 1'b0);
    add_req(1'b1, 21'sd888, 1'b0);
    add_req(1'b1, 21'sd88000, 1'b0);
    add_req(1'b1, 21'sd87999, 1'b0);
    add_req(1'b0, 21'sd4000, 1'b0);
    add_req(1'b1, 21'sd300000, 1'b1);
    // Random requests: near table keys, within the stated range, or any bit pattern.
    for (int n = 0; n < 1730; n++) begin
      k = $urandom_range(0, 1);
      sel = $urandom_range(0, 9);
      j = $urandom_range(0, NUM_POINTS - 1);
      if (sel < 4)
        add_req(k, IN_W'(tab_key(k, j) + $signed($urandom_range(0, 64)) - 32), n == 900);
      else if (sel < 8)
        add_req(k, IN_W'(longint'($urandom_range(0, 1114111)) - 65536), n == 900);
      else
        add_req(k, IN_W'($urandom), n == 900);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_res.size() == 0);
    repeat (150) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
